// File: hw/rtl/wmt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Watchpoint match table package
// Shared types, command codes and beat layouts.
// ----------------------------------------------------------------------------
package wmt_pkg;

    localparam int unsigned SlotsDefault = 8;
    localparam int unsigned InW  = 224;
    localparam int unsigned OutW = 168;
    localparam int unsigned QueueDepth = 2;

    typedef enum logic [2:0] {
        CMD_CHECK   = 3'd0,
        CMD_ADD     = 3'd1,
        CMD_REMOVE  = 3'd2,
        CMD_ENABLE  = 3'd3,
        CMD_COND    = 3'd4,
        CMD_QUERY   = 3'd5,
        CMD_CLEAR   = 3'd6,
        CMD_NOP     = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        OP_ALWAYS = 3'd0,
        OP_EQ     = 3'd1,
        OP_NE     = 3'd2,
        OP_LT     = 3'd3,
        OP_LE     = 3'd4,
        OP_GT     = 3'd5,
        OP_GE     = 3'd6,
        OP_NZ     = 3'd7
    } cond_op_t;

    typedef struct packed {
        logic [63:0] cond_operand;
        logic [2:0]  cond_op;
        logic        enable_bit;
        logic [31:0] target_id;
        logic [1:0]  watch_kind;
        logic [3:0]  cpu_tag;
        logic [63:0] access_value;
        logic [15:0] span_bytes;
        logic [31:0] address;
        logic        is_write;
        logic [2:0]  cmd;
    } item_t;

    typedef struct packed {
        logic        any_hit;
        logic        changed;
        logic [63:0] before_value;
        logic [63:0] now_value;
        logic [31:0] report_id;
        logic        ok;
        logic        report_kind;
    } result_t;

    function automatic logic cond_holds(logic [2:0] op, logic [63:0] v, logic [63:0] rhs);
        logic r;
        case (op)
            OP_EQ:   r = (v == rhs);
            OP_NE:   r = (v != rhs);
            OP_LT:   r = (v < rhs);
            OP_LE:   r = (v <= rhs);
            OP_GT:   r = (v > rhs);
            OP_GE:   r = (v >= rhs);
            OP_NZ:   r = (v != 64'd0);
            default: r = 1'b1;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/watchpoint_match_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Watchpoint match table
// Table of watch slots with commands and access checks over a beat stream.
// ----------------------------------------------------------------------------
// Commands other than a check give one reply beat, registered in the engine's
// output register, and the engine takes one such command per cycle while that
// register is free. An access check walks the slots one per cycle, gives a
// report beat for each triggered slot and closes with a status beat; the engine
// takes its next command once the check has passed through ST_EMIT back to
// ST_IDLE. A result beat that waits on m_tready holds the engine. A two-entry
// queue separates intake from the engine.
module watchpoint_match_table #(
    parameter int unsigned SLOTS = wmt_pkg::SlotsDefault
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // cmd
    input  wire logic [2:0]                s_tuser,
    // is_write, address, span_bytes, access_value, cpu_tag, watch_kind,
    // target_id, enable_bit, cond_op, cond_operand
    input  wire logic [wmt_pkg::InW-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // report_kind
    output logic                           m_tuser,
    // ok, report_id, now_value, before_value, changed, any_hit
    output logic [wmt_pkg::OutW-1:0]       m_tdata,
    output logic                           m_tlast
);
    import wmt_pkg::*;

    logic  q_valid, q_ready;
    item_t q_item;

    wmt_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tuser, .s_tdata,
        .q_valid, .q_ready, .q_item
    );

    wmt_back #(.SLOTS(SLOTS)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_item,
        .m_tvalid, .m_tready, .m_tuser, .m_tdata, .m_tlast
    );

endmodule
`default_nettype wire

// File: hw/rtl/wmt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Watchpoint front end
// Accepts input beats, unpacks them and queues them for the slot engine.
// ----------------------------------------------------------------------------
module wmt_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [2:0]           s_tuser,
    input  wire logic [wmt_pkg::InW-1:0] s_tdata,
    output logic                      q_valid,
    input  wire logic                 q_ready,
    output wmt_pkg::item_t            q_item
);
    import wmt_pkg::*;

    localparam int unsigned PW = $clog2(QueueDepth);

    item_t            mem_reg [QueueDepth];
    logic [PW-1:0]    wp_reg, rp_reg;
    logic [PW:0]      cnt_reg;
    logic             push, pop;

    assign s_tready = (cnt_reg != (PW+1)'(QueueDepth));
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = mem_reg[rp_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                mem_reg[wp_reg] <= item_t'({s_tdata[$bits(item_t)-4:0], s_tuser});
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (PW+1)'(QueueDepth)) else $error("queue overfilled");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> cnt_reg != '0) else $error("pop from empty queue");
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> cnt_reg != '0) else $error("push lost");

endmodule
`default_nettype wire

// File: hw/rtl/wmt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Watchpoint slot engine
// Carries out one command at a time, scanning one slot per cycle while the output register is free.
// ----------------------------------------------------------------------------
module wmt_back #(
    parameter int unsigned SLOTS = wmt_pkg::SlotsDefault
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  q_valid,
    output logic                       q_ready,
    input  wire wmt_pkg::item_t        q_item,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic                       m_tuser,
    output logic [wmt_pkg::OutW-1:0]   m_tdata,
    output logic                       m_tlast
);
    import wmt_pkg::*;

    localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} state_t;

    state_t            state_reg;
    item_t             it_reg;
    logic [IW:0]       idx_reg;
    logic              hit_reg;
    logic [31:0]       next_id_reg;
    logic [SLOTS-1:0]  valid_reg;
    logic [31:0]       id_reg      [SLOTS];
    logic [31:0]       start_reg   [SLOTS];
    logic [15:0]       span_reg    [SLOTS];
    logic [1:0]        kind_reg    [SLOTS];
    logic              en_reg      [SLOTS];
    logic [3:0]        cpu_reg     [SLOTS];
    logic [2:0]        cop_reg     [SLOTS];
    logic [63:0]       copnd_reg   [SLOTS];
    logic [63:0]       now_reg     [SLOTS];
    logic [63:0]       bef_reg     [SLOTS];
    logic              out_valid_reg, out_last_reg;
    result_t           out_reg;

    logic [IW-1:0]     idx;
    logic              match, cond;
    logic [32:0]       ws, we, as_, ae;
    logic              found, free_any;
    logic [IW-1:0]     found_idx, free_idx;
    logic              out_free;
    logic              out_load;
    logic              out_last_next;
    result_t           out_next;

    assign idx      = idx_reg[IW-1:0];
    assign out_free = !out_valid_reg || m_tready;
    assign q_ready  = (state_reg == ST_IDLE) && out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_reg.report_kind;
    assign m_tdata  = OutW'(out_reg[$bits(result_t)-1:1]);

    always_comb begin
        ws  = {1'b0, start_reg[idx]};
        we  = ws + {17'd0, span_reg[idx]} - 33'd1;
        as_ = {1'b0, it_reg.address};
        ae  = as_ + {17'd0, it_reg.span_bytes} - 33'd1;
        match = valid_reg[idx] && en_reg[idx]
            && (kind_reg[idx][1] || kind_reg[idx] == {1'b0, it_reg.is_write})
            && !(it_reg.cpu_tag != 4'd0 && cpu_reg[idx] != 4'd0
                 && it_reg.cpu_tag != cpu_reg[idx])
            && it_reg.span_bytes != 16'd0 && span_reg[idx] != 16'd0
            && !(we < as_ || ws > ae);
        cond = cond_holds(cop_reg[idx], it_reg.access_value, copnd_reg[idx]);
    end

    // Lookups for the single-reply commands operate on the queue head.
    always_comb begin
        found = 1'b0; found_idx = '0; free_any = 1'b0; free_idx = '0;
        for (int i = SLOTS-1; i >= 0; i--) begin
            if (valid_reg[i] && id_reg[i] == q_item.target_id) begin
                found = 1'b1; found_idx = IW'(i);
            end
            if (!valid_reg[i]) begin
                free_any = 1'b1; free_idx = IW'(i);
            end
        end
    end

    always_comb begin
        out_next      = '0;
        out_last_next = 1'b1;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    out_load = (cmd_t'(q_item.cmd) != CMD_CHECK);
                    case (cmd_t'(q_item.cmd))
                        CMD_ADD: begin
                            out_next.ok        = free_any;
                            out_next.report_id = free_any ? next_id_reg : 32'd0;
                        end
                        CMD_REMOVE, CMD_ENABLE, CMD_COND: out_next.ok = found;
                        CMD_QUERY: begin
                            if (found) begin
                                out_next.ok           = 1'b1;
                                out_next.report_id    = q_item.target_id;
                                out_next.now_value    = now_reg[found_idx];
                                out_next.before_value = bef_reg[found_idx];
                                out_next.changed      =
                                    now_reg[found_idx] != bef_reg[found_idx];
                            end
                        end
                        CMD_CLEAR: out_next.ok = 1'b1;
                        default: out_next.ok = 1'b0;
                    endcase
                end
            end
            ST_SCAN: begin
                if (out_free) begin
                    if (idx_reg == (IW+1)'(SLOTS)) begin
                        out_load         = 1'b1;
                        out_next.ok      = 1'b1;
                        out_next.any_hit = hit_reg;
                    end else if (match && cond) begin
                        out_load              = 1'b1;
                        out_last_next         = 1'b0;
                        out_next.report_kind  = 1'b1;
                        out_next.ok           = 1'b1;
                        out_next.report_id    = id_reg[idx];
                        out_next.now_value    = it_reg.access_value;
                        out_next.before_value = now_reg[idx];
                        out_next.changed      = it_reg.access_value != now_reg[idx];
                    end
                end
            end
            default: out_load = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            next_id_reg   <= 32'd1;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
        end else begin
            if (out_load) begin
                out_valid_reg <= 1'b1;
                out_last_reg  <= out_last_next;
                out_reg       <= out_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid && out_free) begin
                        it_reg <= q_item;
                        case (cmd_t'(q_item.cmd))
                            CMD_CHECK: begin
                                idx_reg   <= '0;
                                hit_reg   <= 1'b0;
                                state_reg <= ST_SCAN;
                            end
                            CMD_ADD: begin
                                if (free_any) begin
                                    valid_reg[free_idx] <= 1'b1;
                                    id_reg[free_idx]    <= next_id_reg;
                                    start_reg[free_idx] <= q_item.address;
                                    span_reg[free_idx]  <= q_item.span_bytes;
                                    kind_reg[free_idx]  <= q_item.watch_kind;
                                    en_reg[free_idx]    <= q_item.enable_bit;
                                    cpu_reg[free_idx]   <= q_item.cpu_tag;
                                    cop_reg[free_idx]   <= q_item.cond_op;
                                    copnd_reg[free_idx] <= q_item.cond_operand;
                                    now_reg[free_idx]   <= '0;
                                    bef_reg[free_idx]   <= '0;
                                    next_id_reg         <= next_id_reg + 32'd1;
                                end
                            end
                            CMD_REMOVE, CMD_ENABLE, CMD_COND: begin
                                if (found) begin
                                    if (q_item.cmd == CMD_REMOVE)
                                        valid_reg[found_idx] <= 1'b0;
                                    else if (q_item.cmd == CMD_ENABLE)
                                        en_reg[found_idx] <= q_item.enable_bit;
                                    else begin
                                        cop_reg[found_idx]   <= q_item.cond_op;
                                        copnd_reg[found_idx] <= q_item.cond_operand;
                                    end
                                end
                            end
                            CMD_CLEAR: valid_reg <= '0;
                            default: ;
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (out_free) begin
                        if (idx_reg == (IW+1)'(SLOTS)) begin
                            state_reg <= ST_EMIT;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                            if (match) begin
                                bef_reg[idx] <= now_reg[idx];
                                now_reg[idx] <= it_reg.access_value;
                                if (cond) hit_reg <= 1'b1;
                            end
                        end
                    end
                end
                ST_EMIT: state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> out_valid_reg && $stable(out_reg))
        else $error("result lost under stall");
    a_trig_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.report_kind) |-> !out_last_reg)
        else $error("trigger report marked last");
    a_idle_take: assert property (@(posedge aclk) disable iff (!aresetn)
        q_ready |-> state_reg == ST_IDLE) else $error("take while busy");

endmodule
`default_nettype wire
